>>> sv/ccf_pkg.sv
// Shared types and constants of the clamped 2D convolution filter.
package ccf_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 1024;
    localparam int KERNEL_SIZE_DEF = 3;

    localparam int PIX_W    = 8;
    localparam int COEF_W   = 12;
    localparam int KROW_W   = 60;
    localparam int CFG_DIM_W = 11;
    localparam int DIM_W    = 13;
    localparam int PROD_W   = 21;
    localparam int RSUM_W   = 24;
    localparam int TSUM_W   = 27;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW3  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KROW4  = 3'd6;

    localparam logic [TSUM_W-1:0] SUM_SAT = TSUM_W'(255 * 256);
    localparam logic [PIX_W-1:0]  PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0]  PIX_MIN = 8'd0;

    typedef struct packed {
        logic acc;
        logic adv;
    } t_cell_ctl;

endpackage

>>> sv/clamped_2d_convolution_filter.sv
// Top level of the clamped 2D convolution filter: counters, masks, cell chain, output stage.
// An accepted transaction's result reaches the master side through r_v1, r_v2, r_v3, r_ov.
// Throughput: one pixel per cycle while the output is not stalled.
// Results start once the window lookahead of floor(K/2) rows plus floor(K/2) pixels is in.
// Reset (synchronous, active low) clears counters, valids and kernel rows, sets width and
// height to 1024; line buffers are not cleared, out-of-frame window taps are masked to zero.
module clamped_2d_convolution_filter #(
    parameter int MAX_WIDTH   = ccf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = ccf_pkg::MAX_HEIGHT_DEF,
    parameter int KERNEL_SIZE = ccf_pkg::KERNEL_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] pixel_in
    input  logic                              s_axis_tuser,  // [0] kind
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,  // [7:0] pixel_out
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ccf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ccf_pkg::KROW_W-1:0]        i_cfg_data
);
    import ccf_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT) + 2;
    localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT) + 2;
    localparam int H     = KERNEL_SIZE / 2;

    logic [CFG_DIM_W-1:0] r_cfg_w, r_cfg_h;
    logic [KROW_W-1:0]    r_kern [5];

    logic [AW-1:0]    r_col, r_ocol;
    logic [RW-1:0]    r_row, r_orow;
    logic [POS_W-1:0] r_pos, r_opos;

    logic [DIM_W-1:0] w_eff, h_eff;
    logic [POS_W-1:0] area, delay;
    logic [AW-1:0]    col_eff, n_col;
    logic             acc, adv, produce, fend, col_wrap;
    logic [PIX_W-1:0] pix;

    logic [KERNEL_SIZE-1:0] r_rmask, r_cmask, n_rmask, n_cmask;
    logic r_v1, r_v2, r_v3, r_ov;
    logic r_fe1, r_fe2, r_fe3, r_ofe;
    logic [PIX_W-1:0] r_opix, n_opix;

    t_cell_ctl ctl;
    logic [PIX_W-1:0] tap [KERNEL_SIZE+1];
    logic signed [RSUM_W-1:0] row_sum [KERNEL_SIZE];
    logic signed [TSUM_W-1:0] total;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_DIM_W'(1024);
            r_cfg_h <= CFG_DIM_W'(1024);
            for (int i = 0; i < 5; i++) r_kern[i] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_cfg_w   <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_HEIGHT: r_cfg_h   <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_KROW0:  r_kern[0] <= i_cfg_data;
                CFG_KROW1:  r_kern[1] <= i_cfg_data;
                CFG_KROW2:  r_kern[2] <= i_cfg_data;
                CFG_KROW3:  r_kern[3] <= i_cfg_data;
                CFG_KROW4:  r_kern[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_w == '0) w_eff = DIM_W'(1);
        else if (DIM_W'(r_cfg_w) > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
        else w_eff = DIM_W'(r_cfg_w);
        if (r_cfg_h == '0) h_eff = DIM_W'(1);
        else if (DIM_W'(r_cfg_h) > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
        else h_eff = DIM_W'(r_cfg_h);
    end

    assign area  = POS_W'(w_eff) * POS_W'(h_eff);
    assign delay = POS_W'(H) * POS_W'(w_eff) + POS_W'(H);

    assign adv           = !r_ov || m_axis_tready;
    assign s_axis_tready = adv;
    assign acc           = adv && s_axis_tvalid;

    assign col_eff  = (DIM_W'(r_col) >= w_eff) ? AW'(w_eff - DIM_W'(1)) : r_col;
    assign col_wrap = (DIM_W'(col_eff) + DIM_W'(1)) >= w_eff;
    assign produce  = r_pos >= delay;
    assign fend     = (r_opos + POS_W'(1)) >= area;
    assign pix      = (s_axis_tuser || (DIM_W'(r_row) >= h_eff)) ? '0 : s_axis_tdata;
    assign n_col    = ((produce && fend) || col_wrap) ? '0 : col_eff + AW'(1);

    always_comb begin
        for (int d = 0; d < KERNEL_SIZE; d++) begin
            n_rmask[d] = (DIM_W'(r_orow) + DIM_W'(d) >= DIM_W'(H)) &&
                         (DIM_W'(r_orow) + DIM_W'(d) < h_eff + DIM_W'(H));
            n_cmask[d] = (DIM_W'(r_ocol) + DIM_W'(d) >= DIM_W'(H)) &&
                         (DIM_W'(r_ocol) + DIM_W'(d) < w_eff + DIM_W'(H));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pos  <= '0;
            r_ocol <= '0;
            r_orow <= '0;
            r_opos <= '0;
        end else if (acc) begin
            if (produce && fend) begin
                r_col  <= '0;
                r_row  <= '0;
                r_pos  <= '0;
                r_ocol <= '0;
                r_orow <= '0;
                r_opos <= '0;
            end else begin
                r_col <= n_col;
                r_pos <= r_pos + POS_W'(1);
                if (col_wrap) r_row <= r_row + RW'(1);
                if (produce) begin
                    r_opos <= r_opos + POS_W'(1);
                    if (DIM_W'(r_ocol) + DIM_W'(1) >= w_eff) begin
                        r_ocol <= '0;
                        r_orow <= r_orow + RW'(1);
                    end else begin
                        r_ocol <= r_ocol + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rmask <= n_rmask;
            r_cmask <= n_cmask;
        end
    end

    assign ctl.acc = acc;
    assign ctl.adv = adv;
    assign tap[0]  = pix;

    for (genvar c = 0; c < KERNEL_SIZE; c++) begin : g_cell
        ccf_cell #(
            .KERNEL_SIZE(KERNEL_SIZE),
            .MAX_WIDTH  (MAX_WIDTH)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_wr_addr(col_eff),
            .i_rd_addr(n_col),
            .i_tap    (tap[c]),
            .i_coefs  (r_kern[KERNEL_SIZE-1-c]),
            .i_rmask  (r_rmask[KERNEL_SIZE-1-c]),
            .i_cmask  (r_cmask),
            .o_tap    (tap[c+1]),
            .o_row_sum(row_sum[c])
        );
    end

    always_comb begin
        total = '0;
        for (int c = 0; c < KERNEL_SIZE; c++) begin
            total = total + TSUM_W'(row_sum[c]);
        end
        if (total > $signed(SUM_SAT)) n_opix = PIX_MAX;
        else if (total < 0) n_opix = PIX_MIN;
        else n_opix = PIX_W'((total + TSUM_W'(128)) >>> 8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v1 <= acc && produce;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fe1  <= fend;
            r_fe2  <= r_fe1;
            r_fe3  <= r_fe2;
            r_ofe  <= r_fe3;
            r_opix <= n_opix;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_opix;
    assign m_axis_tlast  = r_ofe;

endmodule

>>> sv/ccf_cell.sv
// One kernel row: line buffer, window shift register, masked products and row sum.
module ccf_cell #(
    parameter int KERNEL_SIZE = 3,
    parameter int MAX_WIDTH   = 1024
) (
    input  logic                                    i_clk,
    input  ccf_pkg::t_cell_ctl                      i_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]            i_wr_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]            i_rd_addr,
    input  logic [ccf_pkg::PIX_W-1:0]               i_tap,
    input  logic [ccf_pkg::KROW_W-1:0]              i_coefs,
    input  logic                                    i_rmask,
    input  logic [KERNEL_SIZE-1:0]                  i_cmask,
    output logic [ccf_pkg::PIX_W-1:0]               o_tap,
    output logic signed [ccf_pkg::RSUM_W-1:0]       o_row_sum
);
    import ccf_pkg::*;

    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd;
    logic [PIX_W-1:0] r_win [KERNEL_SIZE];
    logic signed [PROD_W-1:0] r_prod [KERNEL_SIZE];
    logic signed [PROD_W-1:0] n_prod [KERNEL_SIZE];
    logic signed [RSUM_W-1:0] r_sum;
    logic signed [RSUM_W-1:0] n_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc) begin
            mem[i_wr_addr] <= i_tap;
            r_rd <= (i_rd_addr == i_wr_addr) ? i_tap : mem[i_rd_addr];
        end
    end

    assign o_tap = r_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc) begin
            r_win[0] <= i_tap;
            for (int j = 1; j < KERNEL_SIZE; j++) begin
                r_win[j] <= r_win[j-1];
            end
        end
    end

    // r_win[j] is window column KERNEL_SIZE-1-j
    always_comb begin
        for (int j = 0; j < KERNEL_SIZE; j++) begin
            if (i_rmask && i_cmask[KERNEL_SIZE-1-j]) begin
                n_prod[j] = PROD_W'($signed({1'b0, r_win[j]})) *
                    PROD_W'($signed(i_coefs[COEF_W*(KERNEL_SIZE-1-j) +: COEF_W]));
            end else begin
                n_prod[j] = '0;
            end
        end
        n_sum = '0;
        for (int j = 0; j < KERNEL_SIZE; j++) begin
            n_sum = n_sum + RSUM_W'(r_prod[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_prod <= n_prod;
            r_sum  <= n_sum;
        end
    end

    assign o_row_sum = r_sum;

endmodule

>>> sv/ccf_checker.sv
// Port-level checker for the clamped 2D convolution filter, bound to the top level.
module ccf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_ready_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stage");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind clamped_2d_convolution_filter ccf_checker u_ccf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);
